[rtl/mse_pkg.sv]
// Shared types for the merge sort engine: sequencer and top-level state
// encodings, and the control bundle between the merge sequencer and the top.
// No dependencies.
package mse_pkg;

    localparam int DATA_W = 32;

    // Top-level phases: load a batch, sort it, stream it out
    typedef enum logic [2:0] {
        T_LOAD,
        T_START,
        T_SORT,
        T_OUT_RD,
        T_OUT_WAIT
    } mse_top_state_t;

    // Merge sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_PASS,
        S_RUN,
        S_FILL_A,
        S_FILL_B,
        S_MERGE,
        S_REFILL,
        S_COPY_RD,
        S_COPY_WR,
        S_NEXT
    } mse_seq_state_t;

    // Control bundle from the merge sequencer to the memories
    typedef struct packed {
        logic rd_en;    // read source memory at rd_addr
        logic wr_en;    // write destination memory at wr_addr
        logic src_sel;  // 0: store is source, scratch is destination; 1: swapped
        logic done;     // one-cycle pulse, sort finished
    } mse_ctl_t;

endpackage

[rtl/merge_sort_engine.sv]
// Merge sort engine top level: batch load, ping-pong element memories,
// result streaming. Depends on mse_pkg and mse_merge_seq.
//
//  channel | dir | fields (tdata low bit up / tuser / tlast)
//  --------+-----+-----------------------------------------------
//  s_*     | in  | tdata: value[31:0]; tlast: last
//  m_*     | out | tdata: sorted_value[31:0]; tuser: dropped; tlast: last_res
//
// Loading takes one cycle per request; values past MAX_ITEMS are dropped.
// Sorting n values takes ceil(log2 n) passes of the merge sequencer, each bounded
// by the single compare unit and the single read port of the source memory.
// Results leave one at a time, each read from memory before it is shown.
// s_tready is low from the last request of a batch until its final result
// is taken; m_tvalid holds with its data while m_tready is low.
// Reset is asynchronous and clears all control state; memories need no clearing.
module merge_sort_engine #(
    parameter int MAX_ITEMS = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [31:0]                s_tdata,   // value[31:0]
    input  logic                       s_tlast,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [31:0]                m_tdata,   // sorted_value[31:0]
    output logic                       m_tlast,
    output logic                       m_tuser    // dropped
);
    import mse_pkg::*;

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam int AW    = $clog2(MAX_ITEMS);

    mse_top_state_t      state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                ovf_reg, ovf_next;
    logic [CNT_W-1:0]    out_idx_reg, out_idx_next;

    logic [DATA_W-1:0]   store_mem   [MAX_ITEMS];
    logic [DATA_W-1:0]   scratch_mem [MAX_ITEMS];
    logic [DATA_W-1:0]   store_rd_reg;
    logic [DATA_W-1:0]   scratch_rd_reg;

    logic                in_req;
    logic                out_req;
    logic                load_wr;
    logic                seq_start;
    logic [AW-1:0]       seq_rd_addr;
    logic [AW-1:0]       seq_wr_addr;
    logic [DATA_W-1:0]   seq_wr_data;
    logic [DATA_W-1:0]   src_rd_data;
    mse_ctl_t            ctl;

    logic                store_we, store_re, scratch_we, scratch_re;
    logic [AW-1:0]       store_wa, store_ra, scratch_ra;
    logic [DATA_W-1:0]   store_wd;
    logic                out_rd;

    assign in_req  = s_tvalid && s_tready;
    assign out_req = m_tvalid && m_tready;
    assign load_wr = in_req && (cnt_reg < CNT_W'(MAX_ITEMS));

    // Merge sequencer
    mse_merge_seq #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (seq_start),
        .count   (cnt_reg),
        .rd_data (src_rd_data),
        .rd_addr (seq_rd_addr),
        .wr_addr (seq_wr_addr),
        .wr_data (seq_wr_data),
        .ctl     (ctl)
    );

    assign src_rd_data = ctl.src_sel ? scratch_rd_reg : store_rd_reg;

    // Memory port steering: load and sort writes, sort and output reads
    assign out_rd     = (state_reg == T_OUT_RD);
    assign store_we   = load_wr || (ctl.wr_en && ctl.src_sel);
    assign store_wa   = load_wr ? cnt_reg[AW-1:0] : seq_wr_addr;
    assign store_wd   = load_wr ? s_tdata : seq_wr_data;
    assign scratch_we = ctl.wr_en && !ctl.src_sel;
    assign store_re   = (out_rd && !ctl.src_sel) || (ctl.rd_en && !ctl.src_sel);
    assign scratch_re = (out_rd && ctl.src_sel) || (ctl.rd_en && ctl.src_sel);
    assign store_ra   = out_rd ? out_idx_reg[AW-1:0] : seq_rd_addr;
    assign scratch_ra = out_rd ? out_idx_reg[AW-1:0] : seq_rd_addr;

    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_mem[store_wa] <= store_wd;
        end
        if (store_re)
        begin
            store_rd_reg <= store_mem[store_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (scratch_we)
        begin
            scratch_mem[seq_wr_addr] <= seq_wr_data;
        end
        if (scratch_re)
        begin
            scratch_rd_reg <= scratch_mem[scratch_ra];
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= T_LOAD;
            cnt_reg     <= '0;
            ovf_reg     <= 1'b0;
            out_idx_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            ovf_reg     <= ovf_next;
            out_idx_reg <= out_idx_next;
        end
    end

    // Batch phase sequencing
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        ovf_next     = ovf_reg;
        out_idx_next = out_idx_reg;
        seq_start    = 1'b0;

        case (state_reg)
            T_LOAD:
            begin
                if (in_req)
                begin
                    if (load_wr)
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (s_tlast)
                    begin
                        state_next = T_START;
                    end
                end
            end

            T_START:
            begin
                seq_start  = 1'b1;
                state_next = T_SORT;
            end

            T_SORT:
            begin
                if (ctl.done)
                begin
                    out_idx_next = '0;
                    state_next   = T_OUT_RD;
                end
            end

            T_OUT_RD:
            begin
                state_next = T_OUT_WAIT;
            end

            // Hold the result until taken; the read register stays put
            T_OUT_WAIT:
            begin
                if (out_req)
                begin
                    if (m_tlast)
                    begin
                        cnt_next   = '0;
                        ovf_next   = 1'b0;
                        state_next = T_LOAD;
                    end
                    else
                    begin
                        out_idx_next = out_idx_reg + 1'b1;
                        state_next   = T_OUT_RD;
                    end
                end
            end

            default:
            begin
                state_next = T_LOAD;
            end
        endcase
    end

    assign s_tready = (state_reg == T_LOAD);
    assign m_tvalid = (state_reg == T_OUT_WAIT);
    assign m_tdata  = ctl.src_sel ? scratch_rd_reg : store_rd_reg;
    assign m_tlast  = ((out_idx_reg + 1'b1) == cnt_reg);
    assign m_tuser  = ovf_reg;

    // Input and output never open together
    assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
    else $error("input accepted while a result is pending");

    // Sequencer writes only while sorting
    assert property (@(posedge clk) disable iff (!rst_n)
        ctl.wr_en |-> (state_reg == T_SORT))
    else $error("memory write outside the sort phase");

    // Every shown result lies within the batch
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (out_idx_reg < cnt_reg))
    else $error("result index beyond batch size");

    // Final result clears the batch state
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_req && m_tlast) |=> ((cnt_reg == '0) && !ovf_reg && s_tready))
    else $error("batch state not cleared after final result");

endmodule

[rtl/mse_merge_seq.sv]
// Merge sequencer: bottom-up stable merge sort over two ping-pong memories
// with a single shared signed comparator. Depends on mse_pkg.
module mse_merge_seq #(
    parameter int MAX_ITEMS = 64
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic [$clog2(MAX_ITEMS+1)-1:0]        count,
    input  logic [mse_pkg::DATA_W-1:0]            rd_data,
    output logic [$clog2(MAX_ITEMS)-1:0]          rd_addr,
    output logic [$clog2(MAX_ITEMS)-1:0]          wr_addr,
    output logic [mse_pkg::DATA_W-1:0]            wr_data,
    output mse_pkg::mse_ctl_t                     ctl
);
    import mse_pkg::*;

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam int AW    = $clog2(MAX_ITEMS);
    localparam int SW    = CNT_W + 2;

    mse_seq_state_t      state_reg, state_next;
    logic [CNT_W-1:0]    n_reg, n_next;
    logic [SW-1:0]       w_reg, w_next;
    logic [SW-1:0]       lo_reg, lo_next;
    logic [SW-1:0]       i_reg, i_next;
    logic [SW-1:0]       j_reg, j_next;
    logic [SW-1:0]       k_reg, k_next;
    logic [SW-1:0]       mid_reg, mid_next;
    logic [SW-1:0]       hi_reg, hi_next;
    logic [DATA_W-1:0]   a_reg, a_next;
    logic [DATA_W-1:0]   b_reg, b_next;
    logic                refill_a_reg, refill_a_next;
    logic                sel_reg, sel_next;

    logic [SW-1:0]       n_ext;
    logic [SW-1:0]       two_w;
    logic [SW-1:0]       run_mid;
    logic [SW-1:0]       run_hi_raw;
    logic [SW-1:0]       run_hi;
    logic [SW-1:0]       rd_idx;
    logic                take_left;

    assign n_ext      = SW'(n_reg);
    assign two_w      = w_reg << 1;
    assign run_mid    = lo_reg + w_reg;
    assign run_hi_raw = lo_reg + two_w;
    assign run_hi     = (run_hi_raw > n_ext) ? n_ext : run_hi_raw;

    // Shared comparator: ties go to the left run
    assign take_left = ($signed(a_reg) <= $signed(b_reg));

    // State and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            n_reg        <= '0;
            w_reg        <= '0;
            lo_reg       <= '0;
            i_reg        <= '0;
            j_reg        <= '0;
            k_reg        <= '0;
            mid_reg      <= '0;
            hi_reg       <= '0;
            refill_a_reg <= 1'b0;
            sel_reg      <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            n_reg        <= n_next;
            w_reg        <= w_next;
            lo_reg       <= lo_next;
            i_reg        <= i_next;
            j_reg        <= j_next;
            k_reg        <= k_next;
            mid_reg      <= mid_next;
            hi_reg       <= hi_next;
            refill_a_reg <= refill_a_next;
            sel_reg      <= sel_next;
        end
    end

    // Run head values
    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
    end

    // Next state and memory control
    always_comb
    begin
        state_next    = state_reg;
        n_next        = n_reg;
        w_next        = w_reg;
        lo_next       = lo_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        k_next        = k_reg;
        mid_next      = mid_reg;
        hi_next       = hi_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        refill_a_next = refill_a_reg;
        sel_next      = sel_reg;
        rd_idx        = i_reg;
        wr_data       = rd_data;
        ctl.rd_en     = 1'b0;
        ctl.wr_en     = 1'b0;
        ctl.src_sel   = sel_reg;
        ctl.done      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    n_next     = count;
                    w_next     = SW'(1);
                    lo_next    = '0;
                    sel_next   = 1'b0;
                    state_next = S_PASS;
                end
            end

            // Start a pass, or finish when a run covers the batch
            S_PASS:
            begin
                if (w_reg < n_ext)
                begin
                    lo_next    = '0;
                    state_next = S_RUN;
                end
                else
                begin
                    ctl.done   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            // Set up one pair of runs; a lone run is copied through
            S_RUN:
            begin
                i_next = lo_reg;
                k_next = lo_reg;
                if (run_mid >= n_ext)
                begin
                    mid_next   = n_ext;
                    state_next = S_COPY_RD;
                end
                else
                begin
                    j_next     = run_mid;
                    mid_next   = run_mid;
                    hi_next    = run_hi;
                    rd_idx     = lo_reg;
                    ctl.rd_en  = 1'b1;
                    state_next = S_FILL_A;
                end
            end

            S_FILL_A:
            begin
                a_next     = rd_data;
                rd_idx     = j_reg;
                ctl.rd_en  = 1'b1;
                state_next = S_FILL_B;
            end

            S_FILL_B:
            begin
                b_next     = rd_data;
                state_next = S_MERGE;
            end

            // Emit the smaller head, fetch its successor
            S_MERGE:
            begin
                ctl.wr_en = 1'b1;
                k_next    = k_reg + 1'b1;
                if (take_left)
                begin
                    wr_data = a_reg;
                    if ((i_reg + 1'b1) < mid_reg)
                    begin
                        i_next        = i_reg + 1'b1;
                        rd_idx        = i_reg + 1'b1;
                        ctl.rd_en     = 1'b1;
                        refill_a_next = 1'b1;
                        state_next    = S_REFILL;
                    end
                    else
                    begin
                        // left run drained: copy the rest of the right run
                        i_next     = j_reg;
                        mid_next   = hi_reg;
                        state_next = S_COPY_RD;
                    end
                end
                else
                begin
                    wr_data = b_reg;
                    if ((j_reg + 1'b1) < hi_reg)
                    begin
                        j_next        = j_reg + 1'b1;
                        rd_idx        = j_reg + 1'b1;
                        ctl.rd_en     = 1'b1;
                        refill_a_next = 1'b0;
                        state_next    = S_REFILL;
                    end
                    else
                    begin
                        // right run drained: copy the rest of the left run
                        state_next = S_COPY_RD;
                    end
                end
            end

            S_REFILL:
            begin
                if (refill_a_reg)
                begin
                    a_next = rd_data;
                end
                else
                begin
                    b_next = rd_data;
                end
                state_next = S_MERGE;
            end

            // Copy remaining elements of one run, reading then writing each one
            S_COPY_RD:
            begin
                if (i_reg < mid_reg)
                begin
                    rd_idx     = i_reg;
                    ctl.rd_en  = 1'b1;
                    state_next = S_COPY_WR;
                end
                else
                begin
                    state_next = S_NEXT;
                end
            end

            S_COPY_WR:
            begin
                wr_data    = rd_data;
                ctl.wr_en  = 1'b1;
                i_next     = i_reg + 1'b1;
                k_next     = k_reg + 1'b1;
                state_next = S_COPY_RD;
            end

            // Advance to the next pair, or swap memories and double the width
            S_NEXT:
            begin
                if (run_hi_raw < n_ext)
                begin
                    lo_next    = run_hi_raw;
                    state_next = S_RUN;
                end
                else
                begin
                    sel_next   = ~sel_reg;
                    w_next     = two_w;
                    state_next = S_PASS;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rd_addr = rd_idx[AW-1:0];
    assign wr_addr = k_reg[AW-1:0];

endmodule

[verif/tb_merge_sort_engine.sv]
`timescale 1ns / 1ps
// Testbench for merge_sort_engine: loads batches of signed values and checks
// each sorted result against a behavioral batch sorter. Depends on mse_pkg.
module tb_merge_sort_engine;

    localparam int MAX_ITEMS    = 64;
    localparam int W            = mse_pkg::DATA_W;
    localparam int RANDOM_ITEMS = 16;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 200;
    localparam int HOLD_CYCLES  = 600;

    localparam logic [W-1:0] VAL_MIN = 32'h8000_0000;
    localparam logic [W-1:0] VAL_MAX = 32'h7FFF_FFFF;

    typedef struct packed {
        logic signed [W-1:0] value;
        logic                last;
        logic                dropped;
    } sorted_result_t;

    logic         clk      = 1'b0;
    logic         rst_n    = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [W-1:0] s_tdata  = '0;
    logic         s_tlast  = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [W-1:0] m_tdata;
    logic         m_tlast;
    logic         m_tuser;

    // batch under construction and results still owed by the block
    logic signed [W-1:0] batch_values[$];
    logic signed [W-1:0] sorted_values[$];
    logic                batch_overflow = 1'b0;
    sorted_result_t      pending_sorted[$];
    sorted_result_t      head_result;

    int  error_count  = 0;
    int  cycle_count  = 0;
    int  rx_hold_left = 0;
    bit  steady_flow  = 1'b0;

    merge_sort_engine #(
        .MAX_ITEMS(MAX_ITEMS)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .m_tuser (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Store one accepted value; on the batch end, sort and queue the results
    task automatic load_and_sort(input logic [W-1:0] value, input logic is_last);
        logic signed [W-1:0] key;
        int                  j;
    begin
        if (batch_values.size() < MAX_ITEMS)
            batch_values.push_back(value);
        else
            batch_overflow = 1'b1;
        if (is_last)
        begin
            // insertion sort keeps equal keys in arrival order
            sorted_values = batch_values;
            for (int i = 1; i < sorted_values.size(); i++)
            begin
                key = sorted_values[i];
                j = i - 1;
                while (j >= 0 && sorted_values[j] > key)
                begin
                    sorted_values[j + 1] = sorted_values[j];
                    j--;
                end
                sorted_values[j + 1] = key;
            end
            for (int k = 0; k < sorted_values.size(); k++)
                pending_sorted.push_back('{value:   sorted_values[k],
                                           last:    (k == sorted_values.size() - 1),
                                           dropped: batch_overflow});
            batch_values.delete();
            batch_overflow = 1'b0;
        end
    end
    endtask

    // Offer one request and hold it until the block takes it
    task automatic send_element(input logic [W-1:0] value, input logic is_last);
    begin
        if (!steady_flow)
            while ($urandom_range(99) < 19)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tlast  <= is_last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        load_and_sort(value, is_last);
    end
    endtask

    // Send a batch of random values, marking the final one
    task automatic send_batch(input int count);
        logic [W-1:0] value;
    begin
        value = '0;
        for (int k = 0; k < count; k++)
        begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4: value = $urandom;
                5, 6:          value = $urandom_range(8) - 4;
                7:             value = VAL_MIN + $urandom_range(3);
                8:             value = VAL_MAX - $urandom_range(3);
                default:       ;   // repeat the previous value
            endcase
            send_element(value, k == count - 1);
        end
    end
    endtask

    // Extremes, duplicates, a presorted batch, a single element
    task automatic test_directed();
        logic [W-1:0] mixed[8];
    begin
        mixed = '{32'd0, 32'hFFFF_FFFF, 32'd1, VAL_MAX, VAL_MIN, 32'd7, -32'sd7, 32'd0};
        send_element(VAL_MIN, 1'b1);
        send_element(VAL_MAX, 1'b0);
        send_element(VAL_MIN, 1'b1);
        foreach (mixed[i])
            send_element(mixed[i], i == 7);
        for (int v = -3; v <= 2; v++)
            send_element(v, v == 2);
        for (int i = 0; i < 4; i++)
            send_element(32'd5, i == 3);
        send_element(32'h8000_0001, 1'b0);
        send_element(32'h7FFF_FFFE, 1'b0);
        send_element(32'hFFFF_FFFF, 1'b1);
    end
    endtask

    // Fill the store, then overflow it, dropping the last request too
    task automatic test_capacity();
    begin
        send_batch(MAX_ITEMS + 2);
        send_element(32'd3, 1'b0);
        send_element(32'd1, 1'b1);
    end
    endtask

    // Hold the receiver off while the sender keeps offering a second batch
    task automatic test_output_stall();
    begin
        rx_hold_left <= HOLD_CYCLES;
        send_batch(20);
        send_batch(10);
    end
    endtask

    // Run back-to-back with neither side idling
    task automatic test_steady_stream();
    begin
        steady_flow = 1'b1;
        for (int b = 0; b < 2; b++)
            send_batch($urandom_range(16, 8));
        steady_flow = 1'b0;
    end
    endtask

    // Short batches of random length
    task automatic test_random();
        int sent;
        int count;
    begin
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            count = $urandom_range(12, 1);
            send_batch(count);
            sent += count;
        end
    end
    endtask

    // Count down a receiver hold-off request
    always @(posedge clk)
    begin
        if (rx_hold_left > 0)
            rx_hold_left <= rx_hold_left - 1;
    end

    // Check each accepted result, then pick the next ready value
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_sorted.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, got value %0d %s %0b %s %0b",
                         $time, $signed(m_tdata), "last", m_tlast, "dropped", m_tuser);
                error_count++;
            end
            else
            begin
                head_result = pending_sorted.pop_front();
                if ($signed(m_tdata) !== head_result.value)
                begin
                    $display("%0t: sorted_value mismatch: expected %0d, got %0d",
                             $time, head_result.value, $signed(m_tdata));
                    error_count++;
                end
                if (m_tlast !== head_result.last)
                begin
                    $display("%0t: last_res mismatch: expected %0b, got %0b",
                             $time, head_result.last, m_tlast);
                    error_count++;
                end
                if (m_tuser !== head_result.dropped)
                begin
                    $display("%0t: dropped mismatch: expected %0b, got %0b",
                             $time, head_result.dropped, m_tuser);
                    error_count++;
                end
            end
        end
        if (!rst_n || rx_hold_left > 0)
            m_tready <= 1'b0;
        else if (steady_flow)
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(99) >= 19);
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time, pending_sorted.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_capacity();
        test_output_stall();
        test_steady_stream();
        test_random();

        // drain the block, then watch for stray results
        s_tvalid <= 1'b0;
        while (pending_sorted.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (pending_sorted.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, pending_sorted.size());
            error_count++;
        end
        if (error_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
